// ===== design/tdst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdst_pkg: shared types and constants for the 2D sparse table min/max block
// Table geometry, request and status codes, and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package tdst_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int Levels  = 7;

  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int LvW  = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int AddrW = $clog2(MaxRows * MaxCols * Levels * Levels);
  localparam int DimW = 7;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_BAD_RECT  = 2'd2
  } status_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  localparam logic [0:0] CFG_N_ROWS = 1'b0;
  localparam logic [0:0] CFG_N_COLS = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QUERY,
    BK_QDRAIN,
    BK_BUILD_RD,
    BK_BUILD_WR
  } bk_state_t;

  // entry handed from the front part to the back part
  typedef struct packed {
    req_t              kind;
    logic              last;
    logic              in_range;
    logic [RowW-1:0]   r0;
    logic [ColW-1:0]   c0;
    logic [DimW-1:0]   bottom;
    logic [DimW-1:0]   right;
    logic [DimW-1:0]   top;
    logic [DimW-1:0]   left;
    logic [DataW-1:0]  value;
  } fq_entry_t;

  // table address of position (r, c) at levels (i, j)
  function automatic logic [AddrW-1:0] tbl_addr(input logic [RowW-1:0] r,
                                                input logic [ColW-1:0] c,
                                                input logic [LvW-1:0] i,
                                                input logic [LvW-1:0] j);
    logic [AddrW+8:0] a;
    begin
      a = ((({{(AddrW+9-RowW){1'b0}}, r} * (AddrW+9)'(MaxCols)
            + (AddrW+9)'(c)) * (AddrW+9)'(Levels) + (AddrW+9)'(i))
           * (AddrW+9)'(Levels)) + (AddrW+9)'(j);
      tbl_addr = a[AddrW-1:0];
    end
  endfunction

  // floor log2 of a 7-bit value, capped at the top level
  function automatic logic [LvW-1:0] flog2_cap(input logic [DimW-1:0] v);
    logic [LvW:0] k;
    begin
      k = '0;
      for (int b = 1; b < DimW; b++) begin
        if (v[b]) k = (LvW+1)'(b);
      end
      if (k > (LvW+1)'(Levels - 1)) k = (LvW+1)'(Levels - 1);
      flog2_cap = k[LvW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/tdst_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdst_front: request intake
// Accepts requests, checks load positions, and queues them for the back part.
// ----------------------------------------------------------------------------
module tdst_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic                in_req_type,
  input  wire logic [6:0]          in_top_row,
  input  wire logic [6:0]          in_left_col,
  input  wire logic [6:0]          in_bottom_row,
  input  wire logic [6:0]          in_right_col,
  input  wire logic [31:0]         in_elem_value,
  input  wire logic                in_last_load,
  output tdst_pkg::fq_entry_t      fq_data,
  output logic                     fq_valid,
  input  wire logic                fq_pop
);
  import tdst_pkg::*;

  // two-entry queue
  fq_entry_t   mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  fq_entry_t   ent;
  logic        push_ok;

  always_comb begin
    ent = '0;
    ent.kind = req_t'(in_req_type);
    ent.last = in_last_load;
    ent.in_range = (in_top_row >= 7'd1) && (in_top_row <= 7'(MaxRows)) &&
                   (in_left_col >= 7'd1) && (in_left_col <= 7'(MaxCols));
    ent.r0 = RowW'(in_top_row - 7'd1);
    ent.c0 = ColW'(in_left_col - 7'd1);
    ent.top = in_top_row;
    ent.left = in_left_col;
    ent.bottom = in_bottom_row;
    ent.right = in_right_col;
    ent.value = in_elem_value;
  end

  assign in_full  = (cnt_r == 2'd2);
  assign push_ok  = in_push && !in_full;
  assign fq_valid = (cnt_r != 2'd0);
  assign fq_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt = push_ok ? ~wp_r : wp_r;
    rp_nxt = (fq_pop && fq_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, fq_pop && fq_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= ent;
  end

endmodule
`default_nettype wire

// ===== design/tdst_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdst_back: table store, build sequencer and query engine
// Holds the min/max tables, runs the build sweep, answers queries.
// ----------------------------------------------------------------------------
module tdst_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [6:0]          n_rows,
  input  wire logic [6:0]          n_cols,
  input  wire tdst_pkg::fq_entry_t fq_data,
  input  wire logic                fq_valid,
  output logic                     fq_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [31:0]              out_range_min,
  output logic [31:0]              out_range_max,
  output logic [1:0]               out_status
);
  import tdst_pkg::*;

  localparam int Depth = MaxRows * MaxCols * Levels * Levels;

  logic [DataW-1:0] min_mem [Depth];
  logic [DataW-1:0] max_mem [Depth];

  bk_state_t state_r, state_nxt;

  logic             built_r, built_nxt;
  logic [6:0]       brows_r, bcols_r;
  logic [6:0]       brows_nxt, bcols_nxt;
  logic [LvW-1:0]   li_r, lj_r, i_r, j_r, kx_r, ky_r;
  logic [LvW-1:0]   li_nxt, lj_nxt, i_nxt, j_nxt, kx_nxt, ky_nxt;
  logic [RowW:0]    r_r, r_nxt;
  logic [ColW:0]    c_r, c_nxt;
  logic [RowW-1:0]  qr0_r, qr1_r, qr0_nxt, qr1_nxt;
  logic [ColW-1:0]  qc0_r, qc1_r, qc0_nxt, qc1_nxt;
  logic [2:0]       qk_r, qk_nxt;
  logic             rdv_r;
  logic [DataW-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic             ovld_r, ovld_nxt;
  logic [DataW-1:0] omin_r, omax_r, omin_nxt, omax_nxt;
  status_t          ost_r, ost_nxt;

  // memory port control
  logic             rd_en, wr_en, rd_sel;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [DataW-1:0] wr_min, wr_max;
  logic [DataW-1:0] rmin_r, rmax_r, amin_r, amax_r;
  logic             rd_sel_r;

  // pending write of a built entry; holds off requests for that cycle
  logic             bw_r;
  logic [AddrW-1:0] bw_addr_r;

  // build geometry helpers
  logic [RowW+1:0]  h_w;
  logic [ColW+1:0]  w_w;
  logic [6:0]       nr_sat, nc_sat, qh, qw;
  logic             row_done, col_last;

  assign out_empty     = !ovld_r;
  assign out_range_min = omin_r;
  assign out_range_max = omax_r;
  assign out_status    = ost_r;

  assign nr_sat = (n_rows > 7'(MaxRows)) ? 7'(MaxRows) : n_rows;
  assign nc_sat = (n_cols > 7'(MaxCols)) ? 7'(MaxCols) : n_cols;
  assign h_w = (RowW+2)'(1) << i_r;
  assign w_w = (ColW+2)'(1) << j_r;
  assign qh = fq_data.bottom - fq_data.top + 7'd1;
  assign qw = fq_data.right - fq_data.left + 7'd1;
  assign col_last = ((ColW+2)'(c_r) + 1 + w_w) > (ColW+2)'(bcols_r);
  assign row_done = ((RowW+2)'(r_r) + 1 + h_w) > (RowW+2)'(brows_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (fq_valid && !bw_r) begin
          if (fq_data.kind == REQ_LOAD) begin
            if (fq_data.last && nr_sat != 0 && nc_sat != 0 &&
                !(nr_sat == 7'd1 && nc_sat == 7'd1)) state_nxt = BK_BUILD_RD;
          end else if (!ovld_r) begin
            if (built_r && fq_data.top != 0 && fq_data.left != 0 &&
                fq_data.top <= fq_data.bottom && fq_data.left <= fq_data.right &&
                fq_data.bottom <= brows_r && fq_data.right <= bcols_r)
              state_nxt = BK_QUERY;
          end
        end
      end
      BK_QUERY:    if (qk_r == 3'd3) state_nxt = BK_QDRAIN;
      BK_QDRAIN:   state_nxt = BK_IDLE;
      BK_BUILD_RD: state_nxt = BK_BUILD_WR;
      BK_BUILD_WR: begin
        if (col_last && row_done && i_r == li_r && j_r == lj_r) state_nxt = BK_IDLE;
        else state_nxt = BK_BUILD_RD;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fq_pop = 1'b0;
    built_nxt = built_r;
    brows_nxt = brows_r; bcols_nxt = bcols_r;
    li_nxt = li_r; lj_nxt = lj_r; i_nxt = i_r; j_nxt = j_r;
    kx_nxt = kx_r; ky_nxt = ky_r;
    r_nxt = r_r; c_nxt = c_r;
    qr0_nxt = qr0_r; qr1_nxt = qr1_r; qc0_nxt = qc0_r; qc1_nxt = qc1_r;
    qk_nxt = qk_r;
    lo_nxt = lo_r; hi_nxt = hi_r;
    ovld_nxt = ovld_r && !out_pop;
    omin_nxt = omin_r; omax_nxt = omax_r; ost_nxt = ost_r;
    rd_en = 1'b0; rd_sel = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_min = '0; wr_max = '0;
    case (state_r)
      BK_IDLE: begin
        if (fq_valid && !bw_r && fq_data.kind == REQ_LOAD) begin
          fq_pop = 1'b1;
          built_nxt = 1'b0;
          if (fq_data.in_range) begin
            wr_en = 1'b1;
            wr_addr = tbl_addr(fq_data.r0, fq_data.c0, '0, '0);
            wr_min = fq_data.value;
            wr_max = fq_data.value;
          end
          if (fq_data.last) begin
            built_nxt = 1'b1;
            brows_nxt = nr_sat; bcols_nxt = nc_sat;
            li_nxt = flog2_cap(nr_sat); lj_nxt = flog2_cap(nc_sat);
            i_nxt = '0; j_nxt = LvW'(1);
            if (nc_sat == 7'd1) begin i_nxt = LvW'(1); j_nxt = '0; end
            r_nxt = '0; c_nxt = '0;
          end
        end else if (fq_valid && !bw_r && !ovld_r) begin
          fq_pop = 1'b1;
          kx_nxt = flog2_cap(qh); ky_nxt = flog2_cap(qw);
          qr0_nxt = RowW'(fq_data.top - 7'd1);
          qc0_nxt = ColW'(fq_data.left - 7'd1);
          qr1_nxt = RowW'(fq_data.bottom - (7'd1 << flog2_cap(qh)));
          qc1_nxt = ColW'(fq_data.right - (7'd1 << flog2_cap(qw)));
          qk_nxt = '0;
          if (state_nxt != BK_QUERY) begin
            ovld_nxt = 1'b1;
            omin_nxt = '0; omax_nxt = '0;
            ost_nxt = built_r ? ST_BAD_RECT : ST_NOT_BUILT;
          end
        end
      end
      BK_QUERY: begin
        rd_en = 1'b1;
        case (qk_r)
          3'd0: rd_addr = tbl_addr(qr0_r, qc0_r, kx_r, ky_r);
          3'd1: rd_addr = tbl_addr(qr1_r, qc0_r, kx_r, ky_r);
          3'd2: rd_addr = tbl_addr(qr0_r, qc1_r, kx_r, ky_r);
          default: rd_addr = tbl_addr(qr1_r, qc1_r, kx_r, ky_r);
        endcase
        qk_nxt = qk_r + 3'd1;
      end
      BK_QDRAIN: begin
        ovld_nxt = 1'b1;
        ost_nxt = ST_OK;
        omin_nxt = ($signed(rmin_r) < $signed(lo_r)) ? rmin_r : lo_r;
        omax_nxt = ($signed(rmax_r) > $signed(hi_r)) ? rmax_r : hi_r;
      end
      BK_BUILD_RD: begin
        // first half block
        rd_en = 1'b1;
        rd_sel = 1'b0;
        if (i_r == '0) rd_addr = tbl_addr(RowW'(r_r), ColW'(c_r), '0, j_r - LvW'(1));
        else rd_addr = tbl_addr(RowW'(r_r), ColW'(c_r), i_r - LvW'(1), j_r);
      end
      BK_BUILD_WR: begin
        // second half block; combine with the first once it arrives
        rd_en = 1'b1;
        rd_sel = 1'b1;
        if (i_r == '0)
          rd_addr = tbl_addr(RowW'(r_r), ColW'(c_r + (w_w[ColW:0] >> 1)), '0,
                             j_r - LvW'(1));
        else
          rd_addr = tbl_addr(RowW'(r_r + (h_w[RowW:0] >> 1)), ColW'(c_r),
                             i_r - LvW'(1), j_r);
      end
      default: ;
    endcase

    // accumulate query reads as they come back
    if (rdv_r && !rd_sel_r && (state_r == BK_QUERY || state_r == BK_QDRAIN)) begin
      if (qk_r == 3'd1) begin
        lo_nxt = rmin_r; hi_nxt = rmax_r;
      end else begin
        lo_nxt = ($signed(rmin_r) < $signed(lo_r)) ? rmin_r : lo_r;
        hi_nxt = ($signed(rmax_r) > $signed(hi_r)) ? rmax_r : hi_r;
      end
    end

    // build advance
    if (state_r == BK_BUILD_WR) begin
      if (col_last) begin
        c_nxt = '0;
        if (row_done) begin
          r_nxt = '0;
          if (j_r == lj_r) begin j_nxt = '0; i_nxt = i_r + LvW'(1); end
          else j_nxt = j_r + LvW'(1);
        end else r_nxt = r_r + 1'b1;
      end else c_nxt = c_r + 1'b1;
    end
  end

  // write of a built entry, in the cycle after the second read
  always_ff @(posedge clk) begin
    if (!rst_n) bw_r <= 1'b0;
    else bw_r <= (state_r == BK_BUILD_WR);
    bw_addr_r <= tbl_addr(RowW'(r_r), ColW'(c_r), i_r, j_r);
  end

  // memory ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (bw_r) begin
      min_mem[bw_addr_r] <= ($signed(rmin_r) < $signed(amin_r)) ? rmin_r : amin_r;
      max_mem[bw_addr_r] <= ($signed(rmax_r) > $signed(amax_r)) ? rmax_r : amax_r;
    end else if (wr_en) begin
      min_mem[wr_addr] <= wr_min;
      max_mem[wr_addr] <= wr_max;
    end
    if (rd_en) begin
      rmin_r <= min_mem[rd_addr];
      rmax_r <= max_mem[rd_addr];
    end
    if (rdv_r && !rd_sel_r) begin
      amin_r <= rmin_r;
      amax_r <= rmax_r;
    end
    rd_sel_r <= rd_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      built_r <= 1'b0;
      brows_r <= '0;
      bcols_r <= '0;
      ovld_r <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      brows_r <= brows_nxt;
      bcols_r <= bcols_nxt;
      ovld_r <= ovld_nxt;
      rdv_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    li_r <= li_nxt; lj_r <= lj_nxt; i_r <= i_nxt; j_r <= j_nxt;
    kx_r <= kx_nxt; ky_r <= ky_nxt;
    r_r <= r_nxt; c_r <= c_nxt;
    qr0_r <= qr0_nxt; qr1_r <= qr1_nxt; qc0_r <= qc0_nxt; qc1_r <= qc1_nxt;
    qk_r <= qk_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt;
    omin_r <= omin_nxt; omax_r <= omax_nxt; ost_r <= ost_nxt;
  end

endmodule
`default_nettype wire

// ===== design/two_d_sparse_table_min_max_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_d_sparse_table_min_max_top: 2D sparse table rectangle min/max
// Loads a matrix, builds min/max tables of power-of-two blocks, answers
// rectangle queries.
//
//   channel   handshake              payload
//   in_       in_push / in_full      req_type, corners, elem_value, last_load
//   out_      out_pop / out_empty    range_min, range_max, status
//   cfg_      cfg_valid / cfg_ready  cfg_index (0 n_rows, 1 n_cols), cfg_data
//
// A load is taken while the back part is idle. A query checks the corners,
// makes four reads of the single table read port, and folds the last read
// into the answer; it waits while an earlier answer is not taken. A query
// failing the checks is answered with an error status and no reads. The build
// after a last load makes two reads through the read port per table entry
// over all levels, writing each after its second read; requests queue behind
// it in a two-deep queue. Reset is synchronous and clears the built mark.
// ----------------------------------------------------------------------------
module two_d_sparse_table_min_max_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_req_type,
  input  wire logic [6:0]  in_top_row,
  input  wire logic [6:0]  in_left_col,
  input  wire logic [6:0]  in_bottom_row,
  input  wire logic [6:0]  in_right_col,
  input  wire logic [31:0] in_elem_value,
  input  wire logic        in_last_load,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_range_min,
  output logic [31:0]      out_range_max,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import tdst_pkg::*;

  logic [6:0]  n_rows_r, n_cols_r;
  fq_entry_t   fq_data;
  logic        fq_valid, fq_pop;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_rows_r <= 7'd1;
      n_cols_r <= 7'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_N_ROWS: n_rows_r <= cfg_data;
        CFG_N_COLS: n_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tdst_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_top_row, .in_left_col,
    .in_bottom_row, .in_right_col, .in_elem_value, .in_last_load,
    .fq_data, .fq_valid, .fq_pop
  );

  tdst_back u_back (
    .clk, .rst_n, .n_rows(n_rows_r), .n_cols(n_cols_r),
    .fq_data, .fq_valid, .fq_pop,
    .out_empty, .out_pop, .out_range_min, .out_range_max, .out_status
  );

endmodule
`default_nettype wire
